@@ design/gradient_palette_lookup_core_macros.svh @@
// assertion macros shared by the gradient palette lookup modules
`ifndef GRADIENT_PALETTE_LOOKUP_CORE_MACROS_SVH
`define GRADIENT_PALETTE_LOOKUP_CORE_MACROS_SVH

// clocked check, off while reset is asserted
`define GPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define GPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/gpl_pkg.sv @@
// types and constants for the gradient palette lookup block
`timescale 1ns / 1ps

package gpl_pkg;

  localparam int POS_W  = 16;
  localparam int COL_W  = 24;
  localparam int CH_W   = 8;
  localparam int NCH    = 3;
  localparam int SPAN_W = 17;
  localparam int NUM_W  = 24;
  localparam int QCNT_W = 3;
  localparam int KEY_W  = POS_W + COL_W;

  localparam logic [SPAN_W-1:0] ONE_POS = 17'h10000;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] position;
    logic [COL_W-1:0] key_color;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] blended_color;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [COL_W-1:0] color;
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADD_RD, S_ADD_CMP, S_INS_CHK, S_SHF_RD, S_SHF_WR, S_INS_WR,
    S_LK_RDL, S_LK_CHK, S_SCAN_RD, S_SCAN_CMP, S_MUL, S_DIV, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_LAST
  } rsel_t;

  typedef struct packed {
    logic    load;
    logic    ren;
    rsel_t   rsel;
    logic    we;
    logic    wr_new;
    logic    idx_one;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_to_count;
    logic    ins_save;
    logic    count_inc;
    logic    cap_a;
    logic    cap_wrap;
    logic    cap_b;
    logic    mul;
    logic    div_step;
    logic    set_res;
    logic    res_q;
    status_t st;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic count_zero;
    logic full;
    logic idx_at_count;
    logic idx_at_ins;
    logic key_eq;
    logic key_gt;
    logic wrap;
    logic div_last;
  } stat_t;

endpackage

@@ design/gpl_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module gpl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/gpl_dp.sv @@
// datapath: key store, search registers, blend multiply and divide
`timescale 1ns / 1ps

module gpl_dp #(
  parameter int MAX_KEYS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gpl_pkg::in_item_t in_item,
  input  gpl_pkg::cmd_t     cmd,
  output gpl_pkg::stat_t    stat,
  output gpl_pkg::out_item_t out_item
);

  `include "gradient_palette_lookup_core_macros.svh"

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  logic                        op_r;
  logic [gpl_pkg::POS_W-1:0]   pos_r;
  logic [gpl_pkg::COL_W-1:0]   color_r;
  logic [CW-1:0]               idx_r;
  logic [CW-1:0]               ins_r;
  logic [CW-1:0]               count_r;
  logic [gpl_pkg::POS_W-1:0]   a_pos_r;
  logic [gpl_pkg::COL_W-1:0]   a_col_r;
  logic [gpl_pkg::COL_W-1:0]   b_col_r;
  logic [gpl_pkg::SPAN_W-1:0]  span_r;
  logic [gpl_pkg::SPAN_W-1:0]  off_r;
  logic [gpl_pkg::NUM_W-1:0]   num_r [gpl_pkg::NCH];
  logic [gpl_pkg::NUM_W-1:0]   num_nxt [gpl_pkg::NCH];
  logic [gpl_pkg::CH_W-1:0]    q_r [gpl_pkg::NCH];
  logic [gpl_pkg::CH_W-1:0]    q_nxt [gpl_pkg::NCH];
  logic [gpl_pkg::NUM_W-1:0]   dsh_r;
  logic [gpl_pkg::QCNT_W-1:0]  qcnt_r;
  logic [gpl_pkg::COL_W-1:0]   res_r;
  logic [gpl_pkg::COL_W-1:0]   qres;
  gpl_pkg::status_t            st_r;
  gpl_pkg::out_item_t          out_r;

  logic [gpl_pkg::KEY_W-1:0]   rdata;
  gpl_pkg::key_t               rd_key;
  gpl_pkg::key_t               wr_key;
  logic [CW-1:0]               idx_m1;
  logic [CW-1:0]               cnt_m1;
  logic [IW-1:0]               raddr;
  logic [gpl_pkg::SPAN_W-1:0]  rd_pos_x;
  logic [gpl_pkg::SPAN_W-1:0]  pos_x;
  logic [gpl_pkg::SPAN_W-1:0]  a_pos_x;

  assign rd_key  = gpl_pkg::key_t'(rdata);
  assign idx_m1  = idx_r - CW'(1);
  assign cnt_m1  = count_r - CW'(1);
  assign rd_pos_x = {1'b0, rd_key.pos};
  assign pos_x   = {1'b0, pos_r};
  assign a_pos_x = {1'b0, a_pos_r};

  always_comb begin
    case (cmd.rsel)
      gpl_pkg::RA_IDX:    raddr = idx_r[IW-1:0];
      gpl_pkg::RA_IDX_M1: raddr = idx_m1[IW-1:0];
      gpl_pkg::RA_LAST:   raddr = cnt_m1[IW-1:0];
      default:            raddr = idx_r[IW-1:0];
    endcase
  end

  always_comb begin
    if (cmd.wr_new) begin
      wr_key.pos   = pos_r;
      wr_key.color = color_r;
    end else begin
      wr_key = rd_key;
    end
  end

  gpl_ram #(
    .WIDTH (gpl_pkg::KEY_W),
    .DEPTH (MAX_KEYS)
  ) u_keys (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (idx_r[IW-1:0]),
    .wdata (wr_key),
    .re    (cmd.ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  // per channel products and one restoring divide step
  always_comb begin
    logic [gpl_pkg::NUM_W:0] sum;
    for (int c = 0; c < gpl_pkg::NCH; c++) begin
      sum = (gpl_pkg::NUM_W+1)'(a_col_r[c*gpl_pkg::CH_W +: gpl_pkg::CH_W])
              * (gpl_pkg::NUM_W+1)'(span_r - off_r)
          + (gpl_pkg::NUM_W+1)'(b_col_r[c*gpl_pkg::CH_W +: gpl_pkg::CH_W])
              * (gpl_pkg::NUM_W+1)'(off_r);
      if (cmd.mul) begin
        num_nxt[c] = sum[gpl_pkg::NUM_W-1:0];
        q_nxt[c]   = '0;
      end else if (num_r[c] >= dsh_r) begin
        num_nxt[c] = num_r[c] - dsh_r;
        q_nxt[c]   = {q_r[c][gpl_pkg::CH_W-2:0], 1'b1};
      end else begin
        num_nxt[c] = num_r[c];
        q_nxt[c]   = {q_r[c][gpl_pkg::CH_W-2:0], 1'b0};
      end
      qres[c*gpl_pkg::CH_W +: gpl_pkg::CH_W] = q_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.count_inc) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.opcode;
      pos_r   <= in_item.position;
      color_r <= in_item.key_color;
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.idx_one) begin
      idx_r <= CW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_m1;
    end else if (cmd.idx_to_count) begin
      idx_r <= count_r;
    end
    if (cmd.ins_save) begin
      ins_r <= idx_r;
    end
    if (cmd.cap_a) begin
      a_pos_r <= rd_key.pos;
      a_col_r <= rd_key.color;
    end
    if (cmd.cap_wrap) begin
      // last key blends toward the first key one period later
      a_col_r <= rd_key.color;
      b_col_r <= a_col_r;
      span_r  <= a_pos_x + gpl_pkg::ONE_POS - rd_pos_x;
      off_r   <= (pos_r < a_pos_r) ? pos_x + gpl_pkg::ONE_POS - rd_pos_x : pos_x - rd_pos_x;
    end
    if (cmd.cap_b) begin
      b_col_r <= rd_key.color;
      span_r  <= rd_pos_x - a_pos_x;
      off_r   <= pos_x - a_pos_x;
    end
    if (cmd.mul || cmd.div_step) begin
      for (int c = 0; c < gpl_pkg::NCH; c++) begin
        num_r[c] <= num_nxt[c];
        q_r[c]   <= q_nxt[c];
      end
    end
    if (cmd.mul) begin
      dsh_r  <= {span_r, {(gpl_pkg::NUM_W-gpl_pkg::SPAN_W){1'b0}}};
      qcnt_r <= '1;
    end else if (cmd.div_step) begin
      dsh_r  <= dsh_r >> 1;
      qcnt_r <= qcnt_r - gpl_pkg::QCNT_W'(1);
    end
    if (cmd.set_res) begin
      res_r <= cmd.res_q ? qres : '0;
      st_r  <= cmd.st;
    end
    if (cmd.out_load) begin
      out_r.blended_color <= res_r;
      out_r.status        <= st_r;
    end
  end

  assign stat.opcode       = op_r;
  assign stat.count_zero   = (count_r == '0);
  assign stat.full         = (count_r == CW'(MAX_KEYS));
  assign stat.idx_at_count = (idx_r == count_r);
  assign stat.idx_at_ins   = (idx_r == ins_r);
  assign stat.key_eq       = (rd_key.pos == pos_r);
  assign stat.key_gt       = (rd_key.pos > pos_r);
  assign stat.wrap         = (pos_r < a_pos_r) || (pos_r >= rd_key.pos);
  assign stat.div_last     = (qcnt_r == '0);
  assign out_item          = out_r;

  `GPL_ASSERT(a_count_bound, count_r <= CW'(MAX_KEYS), "key count above capacity")
  `GPL_ASSERT(a_count_step, cmd.count_inc |=> count_r == CW'($past(count_r) + CW'(1)), "count step")
  `GPL_ASSERT(a_wr_range, cmd.we |-> idx_r < CW'(MAX_KEYS), "write beyond key store")

endmodule

@@ design/gpl_ctrl.sv @@
// controller: sequences add, shift, search and blend steps
`timescale 1ns / 1ps

module gpl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  gpl_pkg::stat_t      stat,
  output gpl_pkg::cmd_t       cmd
);

  `include "gradient_palette_lookup_core_macros.svh"

  gpl_pkg::state_t state_r;
  gpl_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;
  logic            in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign in_fire  = in_valid && (state_r == gpl_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gpl_pkg::S_IDLE:     if (in_valid) state_nxt = gpl_pkg::S_DISP;
      gpl_pkg::S_DISP: begin
        if (stat.opcode == gpl_pkg::OP_ADD) state_nxt = gpl_pkg::S_ADD_RD;
        else if (stat.count_zero)            state_nxt = gpl_pkg::S_DONE;
        else                                 state_nxt = gpl_pkg::S_LK_RDL;
      end
      gpl_pkg::S_ADD_RD:
        state_nxt = stat.idx_at_count ? gpl_pkg::S_INS_CHK : gpl_pkg::S_ADD_CMP;
      gpl_pkg::S_ADD_CMP: begin
        if (stat.key_eq)      state_nxt = gpl_pkg::S_DONE;
        else if (stat.key_gt) state_nxt = gpl_pkg::S_INS_CHK;
        else                  state_nxt = gpl_pkg::S_ADD_RD;
      end
      gpl_pkg::S_INS_CHK:
        state_nxt = stat.full ? gpl_pkg::S_DONE : gpl_pkg::S_SHF_RD;
      gpl_pkg::S_SHF_RD:
        state_nxt = stat.idx_at_ins ? gpl_pkg::S_INS_WR : gpl_pkg::S_SHF_WR;
      gpl_pkg::S_SHF_WR:   state_nxt = gpl_pkg::S_SHF_RD;
      gpl_pkg::S_INS_WR:   state_nxt = gpl_pkg::S_DONE;
      gpl_pkg::S_LK_RDL:   state_nxt = gpl_pkg::S_LK_CHK;
      gpl_pkg::S_LK_CHK:
        state_nxt = stat.wrap ? gpl_pkg::S_MUL : gpl_pkg::S_SCAN_RD;
      gpl_pkg::S_SCAN_RD:  state_nxt = gpl_pkg::S_SCAN_CMP;
      gpl_pkg::S_SCAN_CMP:
        state_nxt = stat.key_gt ? gpl_pkg::S_MUL : gpl_pkg::S_SCAN_RD;
      gpl_pkg::S_MUL:      state_nxt = gpl_pkg::S_DIV;
      gpl_pkg::S_DIV:      if (stat.div_last) state_nxt = gpl_pkg::S_FIN;
      gpl_pkg::S_FIN:      state_nxt = gpl_pkg::S_DONE;
      gpl_pkg::S_DONE:     if (out_free) state_nxt = gpl_pkg::S_IDLE;
      default:             state_nxt = gpl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rsel = gpl_pkg::RA_IDX;
    cmd.st   = gpl_pkg::ST_OK;
    case (state_r)
      gpl_pkg::S_IDLE: cmd.load = in_fire;
      gpl_pkg::S_DISP: begin
        if (stat.opcode == gpl_pkg::OP_LOOKUP) begin
          if (stat.count_zero) begin
            cmd.set_res = 1'b1;
            cmd.st      = gpl_pkg::ST_EMPTY;
          end else begin
            cmd.ren = 1'b1;
          end
        end
      end
      gpl_pkg::S_ADD_RD: cmd.ren = !stat.idx_at_count;
      gpl_pkg::S_ADD_CMP: begin
        if (stat.key_eq) begin
          cmd.we      = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.set_res = 1'b1;
        end else if (!stat.key_gt) begin
          cmd.idx_inc = 1'b1;
        end
      end
      gpl_pkg::S_INS_CHK: begin
        if (stat.full) begin
          cmd.set_res = 1'b1;
          cmd.st      = gpl_pkg::ST_FULL;
        end else begin
          cmd.ins_save     = 1'b1;
          cmd.idx_to_count = 1'b1;
        end
      end
      gpl_pkg::S_SHF_RD: begin
        cmd.ren  = !stat.idx_at_ins;
        cmd.rsel = gpl_pkg::RA_IDX_M1;
      end
      gpl_pkg::S_SHF_WR: begin
        cmd.we      = 1'b1;
        cmd.idx_dec = 1'b1;
      end
      gpl_pkg::S_INS_WR: begin
        cmd.we        = 1'b1;
        cmd.wr_new    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.set_res   = 1'b1;
      end
      gpl_pkg::S_LK_RDL: begin
        cmd.cap_a = 1'b1;
        cmd.ren   = 1'b1;
        cmd.rsel  = gpl_pkg::RA_LAST;
      end
      gpl_pkg::S_LK_CHK: begin
        cmd.cap_wrap = stat.wrap;
        cmd.idx_one  = !stat.wrap;
      end
      gpl_pkg::S_SCAN_RD: cmd.ren = 1'b1;
      gpl_pkg::S_SCAN_CMP: begin
        cmd.cap_b   = stat.key_gt;
        cmd.cap_a   = !stat.key_gt;
        cmd.idx_inc = !stat.key_gt;
      end
      gpl_pkg::S_MUL: cmd.mul = 1'b1;
      gpl_pkg::S_DIV: cmd.div_step = 1'b1;
      gpl_pkg::S_FIN: begin
        cmd.set_res = 1'b1;
        cmd.res_q   = 1'b1;
      end
      gpl_pkg::S_DONE: cmd.out_load = out_free;
      default: cmd.load = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != gpl_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  `GPL_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> state_r == gpl_pkg::S_IDLE, "reset not to idle")
  `GPL_ASSERT(a_fire_busy, in_fire |=> state_r == gpl_pkg::S_DISP, "accepted item not dispatched")
  `GPL_ASSERT(a_div_hold, (state_r == gpl_pkg::S_DIV) && !stat.div_last |=> state_r == gpl_pkg::S_DIV, "divide cut short")
  `GPL_ASSERT(a_done_load, (state_r == gpl_pkg::S_DONE) && out_free |=> out_valid_r, "result lost at done")

endmodule

@@ design/gradient_palette_lookup_core.sv @@
// top level of the gradient palette lookup block
`timescale 1ns / 1ps

// channel  | direction | payload              | handshake
// in_      | input     | opcode/position/color | in_valid, in_stall
// out_     | output    | blended_color/status  | out_valid, out_stall
//
// one item at a time; the key store is a single ram with registered read,
// so every key touched takes an address step, then a compare or write step
// add: scans keys up to the match or insert point, then shifts keys up to make room
// lookup: scans keys for the bracket, then a multiply and a bit-serial divide
// reset empties the table (key count to zero); the ram needs no clearing
// a result waiting under out_stall holds only the done step; new items are
// taken again as soon as it moves into the output register

module gradient_palette_lookup_core #(
  parameter int MAX_KEYS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gpl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gpl_pkg::out_item_t out_item
);

  // controller to datapath commands and the status coming back
  gpl_pkg::cmd_t  cmd;
  gpl_pkg::stat_t stat;

  gpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key store, bracket registers, multiply and shift-subtract divide
  gpl_dp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

@@ bench/gradient_palette_lookup_core_tb.sv @@
// testbench for the gradient palette lookup block: key table model and result checks
`timescale 1ns / 1ps

// color keys and their blend, held the way the block holds them
class palette_scoreboard;
  logic [15:0] key_pos[16];
  logic [23:0] key_col[16];
  int unsigned key_cnt;
  gpl_pkg::out_item_t pending[$];
  int unsigned errors;

  function new();
    key_cnt = 0;
    errors = 0;
  endfunction

  // one 8-bit channel, exact blend truncated toward zero
  function logic [7:0] blend_ch(logic [7:0] ca, logic [7:0] cb,
                                logic [16:0] off, logic [16:0] span);
    logic [33:0] num;
    num = ca * (span - off) + cb * off;
    return 8'(num / span);
  endfunction

  function logic [23:0] blend(logic [23:0] ca, logic [23:0] cb,
                              logic [16:0] off, logic [16:0] span);
    return {blend_ch(ca[23:16], cb[23:16], off, span),
            blend_ch(ca[15:8], cb[15:8], off, span),
            blend_ch(ca[7:0], cb[7:0], off, span)};
  endfunction

  // note an accepted item and queue what it should give
  function void note_item(gpl_pkg::in_item_t it);
    gpl_pkg::out_item_t exp_res;
    int unsigned i, j, last;
    logic [16:0] fp, lp, p;
    exp_res = '0;
    p = {1'b0, it.position};
    if (it.opcode == gpl_pkg::OP_ADD) begin
      i = 0;
      while (i < key_cnt && key_pos[i] < it.position) i++;
      if (i < key_cnt && key_pos[i] == it.position) begin
        key_col[i] = it.key_color;
      end else if (key_cnt >= 16) begin
        exp_res.status = gpl_pkg::ST_FULL;
      end else begin
        for (j = key_cnt; j > i; j--) begin
          key_pos[j] = key_pos[j-1];
          key_col[j] = key_col[j-1];
        end
        key_pos[i] = it.position;
        key_col[i] = it.key_color;
        key_cnt++;
      end
    end else if (key_cnt == 0) begin
      exp_res.status = gpl_pkg::ST_EMPTY;
    end else begin
      last = key_cnt - 1;
      fp = {1'b0, key_pos[0]};
      lp = {1'b0, key_pos[last]};
      if (p < fp || p >= lp) begin
        // wrap between the last key and the first key
        exp_res.blended_color = blend(key_col[last], key_col[0],
          (p < fp) ? p + 17'h10000 - lp : p - lp, fp + 17'h10000 - lp);
      end else begin
        i = 0;
        while (i + 1 < last && key_pos[i+1] <= it.position) i++;
        exp_res.blended_color = blend(key_col[i], key_col[i+1],
          p - key_pos[i], 17'(key_pos[i+1] - key_pos[i]));
      end
    end
    pending.push_back(exp_res);
  endfunction

  task check_result(gpl_pkg::out_item_t got);
    gpl_pkg::out_item_t exp_res;
    if (pending.size() == 0) begin
      report("result with nothing expected");
      return;
    end
    exp_res = pending.pop_front();
    if (got.blended_color !== exp_res.blended_color)
      report($sformatf("color got %h want %h", got.blended_color, exp_res.blended_color));
    if (got.status !== exp_res.status)
      report($sformatf("status got %0d want %0d", got.status, exp_res.status));
  endtask

  task report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask
endclass

module gradient_palette_lookup_core_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  gpl_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  gpl_pkg::out_item_t out_item;

  palette_scoreboard sb;
  int unsigned cycles;
  int unsigned sent;
  bit quiet_phase;      // no idling on either side
  bit hold_off;         // long receiver stall in progress
  gpl_pkg::in_item_t stim[$];

  gradient_palette_lookup_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous limit on simulation time, stalls included
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // checks at the rising edge, where the handshake completes
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic gpl_pkg::in_item_t make_item(logic op, logic [15:0] p, logic [23:0] c);
    gpl_pkg::in_item_t it;
    it.opcode = op;
    it.position = p;
    it.key_color = c;
    return it;
  endfunction

  // offer one item and hold it until taken, with random gaps before it
  task automatic send_item(gpl_pkg::in_item_t it);
    int n;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // queue n random items: four in ten adds, the rest lookups
  task automatic random_phase(int n, int max_keys_hint);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 4)
        stim.push_back(make_item(gpl_pkg::OP_ADD,
          (max_keys_hint < 16) ? 16'($urandom_range(0, 15) * 4096) : 16'($urandom),
          24'($urandom)));
      else
        stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'($urandom), 24'($urandom)));
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    quiet_phase = 1'b0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty lookups, single key, wrap both ways, edges, full table
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'h0000, 24'hFFFFFF));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'hFFFF, 24'h000000));
    stim.push_back(make_item(gpl_pkg::OP_ADD, 16'h8000, 24'hFF00FF));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'h0000, 24'h0));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'hFFFF, 24'h0));
    stim.push_back(make_item(gpl_pkg::OP_ADD, 16'h0000, 24'h000000));
    stim.push_back(make_item(gpl_pkg::OP_ADD, 16'hFFFF, 24'hFFFFFF));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'hFFFF, 24'h0));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'h4000, 24'h0));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'hC000, 24'h0));
    stim.push_back(make_item(gpl_pkg::OP_ADD, 16'h8000, 24'h123456));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'h7FFF, 24'h0));
    stim.push_back(make_item(gpl_pkg::OP_LOOKUP, 16'h8000, 24'h0));
    for (int i = 1; i < 15; i++)
      if (i != 8) stim.push_back(make_item(gpl_pkg::OP_ADD, 16'(i * 4096), 24'($urandom)));
    stim.push_back(make_item(gpl_pkg::OP_ADD, 16'h0800, 24'hABCDEF));  // full, rejected
    stim.push_back(make_item(gpl_pkg::OP_ADD, 16'h4000, 24'h00FF00));  // replace while full
    while (stim.size() != 0) send_item(stim.pop_front());

    // fill stress: receiver holds off while items keep coming
    random_phase(40, 16);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      while (stim.size() != 0) send_item(stim.pop_front());
    join
    random_phase(460, 16);
    while (stim.size() != 0) send_item(stim.pop_front());

    quiet_phase = 1'b1;
    random_phase(100, 16);
    while (stim.size() != 0) send_item(stim.pop_front());
    in_valid <= 1'b0;
    drain();
    repeat (100) @(negedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
